// ----- src/lru_key_value_cache_core_defines.svh -----
// assertion macros for the lru key-value cache checker
// depends on nothing; included by the checker file only
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// property must hold at every clock outside reset
`define LKVC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define LKVC_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- src/lkvc_pkg.sv -----
// shared types and constants for the lru key-value cache
// no dependencies
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] PUT_VALUE  = 32'h0000_0000;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             cmp;   // latch the key compare
    logic             upd;   // apply the recency / store update
    logic             op;
    logic             hit;
    logic             fill;  // put miss that takes a free slot
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- src/lkvc_cell.sv -----
// one storage cell of the lru cache row: key, value, valid and recency rank
// depends on lkvc_pkg
`timescale 1ns / 1ps

module lkvc_cell #(
  parameter int IDX = 0,
  parameter int RW  = 4,
  parameter int CW  = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lkvc_pkg::cell_cmd_t       cmd,
  input  logic [RW-1:0]             ref_rank,
  input  logic [CW-1:0]             entry_count,
  input  logic                      hit_in,
  input  logic [RW-1:0]             rank_in,
  input  logic [lkvc_pkg::VAL_W-1:0] value_in,
  output logic                      hit_out,
  output logic [RW-1:0]             rank_out,
  output logic [lkvc_pkg::VAL_W-1:0] value_out
);

  logic                       valid;
  logic                       match_q;
  logic [RW-1:0]              rank;
  logic [lkvc_pkg::KEY_W-1:0] key_q;
  logic [lkvc_pkg::VAL_W-1:0] value_q;

  logic match;
  logic fill_here;
  logic target;
  logic age;

  assign match     = valid && (key_q == cmd.key);
  assign fill_here = cmd.fill && (entry_count == CW'(IDX));

  // target is the slot that becomes most recent
  assign target = cmd.fill ? fill_here : (cmd.hit ? match_q : (valid && (rank == ref_rank)));
  assign age    = valid && !target && (cmd.fill || (rank < ref_rank));

  // the hit slot contributes its rank and value to the chain
  assign hit_out   = hit_in | match;
  assign rank_out  = rank_in | (match ? rank : '0);
  assign value_out = value_in | (match ? value_q : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      match_q <= 1'b0;
      rank    <= '0;
    end else begin
      if (cmd.cmp) begin
        match_q <= match;
      end
      if (cmd.upd) begin
        if (target) begin
          rank <= '0;
          if (fill_here) begin
            valid <= 1'b1;
          end
        end else if (age) begin
          rank <= rank + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && target && (cmd.op == lkvc_pkg::OP_PUT)) begin
      key_q   <= cmd.key;
      value_q <= cmd.value;
    end
  end

endmodule

// ----- src/lru_key_value_cache_core.sv -----
// lru key-value cache: a row of ENTRIES cells, fully associative, rank-based lru.
// each item passes a compare state, then an update state that also loads the output
// register. a new item can enter during the update of the previous one but not during
// its compare; a stalled result holds off the update.
// reset: store empty, capacity 16, result channel empty; no clearing pass.
`timescale 1ns / 1ps

module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         operation,
  input  logic [lkvc_pkg::KEY_W-1:0]   key,
  input  logic signed [lkvc_pkg::VAL_W-1:0] value,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         hit,
  output logic signed [lkvc_pkg::VAL_W-1:0] read_value,
  input  logic                         cfg_write_enable,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_write_data
);

  localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic                         req_op;
  logic [lkvc_pkg::KEY_W-1:0]   req_key;
  logic [lkvc_pkg::VAL_W-1:0]   req_value;
  logic                         hit_q;
  logic [RW-1:0]                hit_rank_q;
  logic [lkvc_pkg::VAL_W-1:0]   hit_value_q;
  logic [CW-1:0]                count;
  logic [lkvc_pkg::CAP_W-1:0]   capacity;

  logic                         accept;
  logic                         out_free;
  logic                         do_upd;
  logic                         fill_ok;
  logic [CW-1:0]                count_m1;
  logic [RW-1:0]                ref_rank;
  lkvc_pkg::cell_cmd_t          cmd;

  logic                         chain_hit   [ENTRIES+1];
  logic [RW-1:0]                chain_rank  [ENTRIES+1];
  logic [lkvc_pkg::VAL_W-1:0]   chain_value [ENTRIES+1];

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !((state == S_IDLE) || ((state == S_UPD) && out_free));
  assign accept     = item_valid && !item_stall;
  assign do_upd     = (state == S_UPD) && out_free;

  // capacity zero acts as one, above ENTRIES saturates
  assign fill_ok = (count == '0) ||
                   ((count < CW'(ENTRIES)) && (CMPW'(count) < CMPW'(capacity)));

  assign count_m1 = count - CW'(1);
  assign ref_rank = hit_q ? hit_rank_q : count_m1[RW-1:0];

  always_comb begin
    cmd.cmp   = (state == S_CMP);
    cmd.upd   = do_upd && ((req_op == lkvc_pkg::OP_PUT) || hit_q);
    cmd.op    = req_op;
    cmd.hit   = hit_q;
    cmd.fill  = (req_op == lkvc_pkg::OP_PUT) && !hit_q && fill_ok;
    cmd.key   = req_key;
    cmd.value = req_value;
  end

  assign chain_hit[0]   = 1'b0;
  assign chain_rank[0]  = '0;
  assign chain_value[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .IDX (g),
      .RW  (RW),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .ref_rank    (ref_rank),
      .entry_count (count),
      .hit_in      (chain_hit[g]),
      .rank_in     (chain_rank[g]),
      .value_in    (chain_value[g]),
      .hit_out     (chain_hit[g+1]),
      .rank_out    (chain_rank[g+1]),
      .value_out   (chain_value[g+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CMP;
      end
      S_CMP: state_next = S_UPD;
      S_UPD: begin
        if (out_free) state_next = accept ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      capacity     <= lkvc_pkg::CAP_RESET;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_enable) begin
        capacity <= cfg_write_data;
      end
      if (do_upd && cmd.fill) begin
        count <= count + CW'(1);
      end
      if (do_upd) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= operation;
      req_key   <= key;
      req_value <= value;
    end
    if (state == S_CMP) begin
      hit_q       <= chain_hit[ENTRIES];
      hit_rank_q  <= chain_rank[ENTRIES];
      hit_value_q <= chain_value[ENTRIES];
    end
    if (do_upd) begin
      hit <= hit_q;
      if (req_op == lkvc_pkg::OP_GET) begin
        read_value <= hit_q ? hit_value_q : lkvc_pkg::MISS_VALUE;
      end else begin
        read_value <= lkvc_pkg::PUT_VALUE;
      end
    end
  end

endmodule

// ----- src/lkvc_checker.sv -----
// port-level checker for the lru key-value cache, bound to the top level
// depends on lru_key_value_cache_core_defines.svh and lkvc_pkg
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_defines.svh"

module lkvc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic                         hit,
  input logic [lkvc_pkg::VAL_W-1:0]   read_value
);

  // a stalled result transaction keeps its payload
  `LKVC_ASSERT(a_result_hold, clk, rst,
    result_valid && result_stall |=> result_valid && $stable(hit) && $stable(read_value),
    "result changed while stalled")

  // without a hit the result is either the miss marker or the put reply
  `LKVC_NEVER(a_miss_value, clk, rst,
    result_valid && !hit && (read_value != lkvc_pkg::MISS_VALUE) &&
    (read_value != lkvc_pkg::PUT_VALUE),
    "miss result carries a stored value")

  // each item goes through its compare state before the next can enter
  `LKVC_ASSERT(a_two_cycle, clk, rst,
    item_valid && !item_stall |=> item_stall,
    "item accepted during compare cycle")

  // nothing is pending right after reset
  `LKVC_ASSERT(a_reset_empty, clk, rst,
    $fell(rst) |-> !result_valid,
    "result valid right after reset")

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .hit          (hit),
  .read_value   (read_value)
);
